// ===== src/dma_chunk_descriptor_generator_defines.svh =====
// Assertion macros shared by the checker of the chunk descriptor generator.
// No dependencies; every macro expects clk and rst_n in scope.
`ifndef DMA_CHUNK_DESCRIPTOR_GENERATOR_DEFINES_SVH
`define DMA_CHUNK_DESCRIPTOR_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DCDG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCDG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dcdg_pkg.sv =====
// Shared constants of the chunk descriptor generator: register indexes and widths.
// No dependencies.
package dcdg_pkg;

    localparam int unsigned ENTRY_W   = 24;
    localparam int unsigned PROD_W    = 7;
    localparam int unsigned PHASE_W   = 6;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 128;
    localparam int unsigned M_USER_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TOTAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRODUCER_TOTAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_PRODUCER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_CAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IN_SHARD_SIZE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_IN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SHARD_SIZE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE     = 3'd7;

endpackage

// ===== src/dma_chunk_descriptor_generator.sv =====
// Chunk descriptor generator: walks a device block one transfer entry per item.
// Depends on dcdg_pkg.
//
//  channel | dir | handshake        | contents
//  --------+-----+------------------+------------------------------------------
//  s_*     | in  | tvalid / tready  | tdata[0] restart
//  m_*     | out | tvalid / tready  | tdata descriptor, tuser past_end,
//          |     |                  | tlast last_entry
//  cfg_*   | in  | cfg_we only      | register index cfg_addr, value cfg_wdata
//
// One item per cycle while m_* does not stall; each item passes through the input
// register and then the result register before its result shows on m_*.
// The walk state is updated in the same cycle the item moves from the input
// register to the result register; that adder/compare loop sets the clock rate.
// Reset clears the walk state, the pipeline valid bits and loads register defaults.
// A stalled m_* side holds the result; the input register still takes one more item.
module dma_chunk_descriptor_generator
    import dcdg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]    cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [23:0] entry_index, [24] owned,
                                            // [56:25] chunk_bytes, [88:57] page_index,
                                            // [120:89] shard_offset, [121] whole_entry,
                                            // [127:122] zero
    output logic [M_USER_W-1:0]  m_tuser,   // [0] past_end
    output logic                 m_tlast
);

    // Configuration registers
    logic [ENTRY_W-1:0] entry_total_reg;
    logic [PROD_W-1:0]  producer_total_reg;
    logic [PHASE_W-1:0] own_producer_reg;
    logic [WORD_W-1:0]  chunk_cap_reg;
    logic [WORD_W-1:0]  in_shard_size_reg;
    logic [WORD_W-1:0]  tiles_per_in_reg;
    logic [WORD_W-1:0]  out_shard_size_reg;
    logic [WORD_W-1:0]  block_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg    <= '0;
            producer_total_reg <= PROD_W'(1);
            own_producer_reg   <= '0;
            chunk_cap_reg      <= WORD_W'(1);
            in_shard_size_reg  <= WORD_W'(1);
            tiles_per_in_reg   <= WORD_W'(1);
            out_shard_size_reg <= WORD_W'(1);
            block_size_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENTRY_TOTAL:    entry_total_reg    <= cfg_wdata[ENTRY_W-1:0];
                REG_PRODUCER_TOTAL: producer_total_reg <= cfg_wdata[PROD_W-1:0];
                REG_OWN_PRODUCER:   own_producer_reg   <= cfg_wdata[PHASE_W-1:0];
                REG_CHUNK_CAP:      chunk_cap_reg      <= cfg_wdata;
                REG_IN_SHARD_SIZE:  in_shard_size_reg  <= cfg_wdata;
                REG_TILES_PER_IN:   tiles_per_in_reg   <= cfg_wdata;
                REG_OUT_SHARD_SIZE: out_shard_size_reg <= cfg_wdata;
                REG_BLOCK_SIZE:     block_size_reg     <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Input register
    logic in_valid_reg;
    logic restart_reg;
    logic out_valid_reg;
    logic advance;

    // Move the held item forward whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            restart_reg <= s_tdata[0];
    end

    // Walk state
    logic [WORD_W-1:0]  cursor_reg,    cursor_next;
    logic [ENTRY_W-1:0] count_reg,     count_next;
    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic [WORD_W-1:0]  in_off_reg,    in_off_next;
    logic [WORD_W-1:0]  out_off_reg,   out_off_next;
    logic [WORD_W-1:0]  page_base_reg, page_base_next;

    // State as seen by this item: a restart zeroes it first.
    logic [WORD_W-1:0]  cur_cursor, cur_in_off, cur_out_off, cur_page;
    logic [ENTRY_W-1:0] cur_count;
    logic [PHASE_W-1:0] cur_phase;

    assign cur_cursor  = restart_reg ? '0 : cursor_reg;
    assign cur_in_off  = restart_reg ? '0 : in_off_reg;
    assign cur_out_off = restart_reg ? '0 : out_off_reg;
    assign cur_page    = restart_reg ? '0 : page_base_reg;
    assign cur_count   = restart_reg ? '0 : count_reg;
    assign cur_phase   = restart_reg ? '0 : phase_reg;

    logic              done;
    logic              in_lt, out_lt, blk_lt;
    logic [WORD_W-1:0] in_room, out_room, blk_room;
    logic [WORD_W-1:0] min_a, min_b, size;
    logic [PROD_W-1:0] phase_inc;
    logic              last;

    always_comb
    begin
        done     = cur_count >= entry_total_reg;
        in_lt    = cur_in_off < in_shard_size_reg;
        out_lt   = cur_out_off < out_shard_size_reg;
        blk_lt   = cur_cursor < block_size_reg;
        // Room left saturates at zero once an offset reaches its limit.
        in_room  = in_lt  ? in_shard_size_reg - cur_in_off   : '0;
        out_room = out_lt ? out_shard_size_reg - cur_out_off : '0;
        blk_room = blk_lt ? block_size_reg - cur_cursor      : '0;
        min_a    = (in_room < blk_room) ? in_room : blk_room;
        min_b    = (min_a < out_room)   ? min_a   : out_room;
        size     = (chunk_cap_reg < min_b) ? chunk_cap_reg : min_b;
        last     = ({1'b0, cur_count} + (ENTRY_W+1)'(1)) == {1'b0, entry_total_reg};
        phase_inc = {1'b0, cur_phase} + PROD_W'(1);
    end

    always_comb
    begin
        cursor_next    = cur_cursor;
        count_next     = cur_count;
        phase_next     = cur_phase;
        in_off_next    = cur_in_off;
        out_off_next   = cur_out_off;
        page_base_next = cur_page;
        if (!done)
        begin
            cursor_next = cur_cursor + size;
            count_next  = cur_count + ENTRY_W'(1);
            // The chunk never runs past a shard, so hitting the room exactly is the wrap.
            if (in_lt)
            begin
                if (size == in_room)
                begin
                    in_off_next    = '0;
                    page_base_next = cur_page + tiles_per_in_reg;
                end
                else
                    in_off_next = cur_in_off + size;
            end
            if (out_lt)
                out_off_next = (size == out_room) ? '0 : cur_out_off + size;
            // Wrap the owner phase at producer_total and also at 64.
            if (phase_inc >= producer_total_reg || phase_inc[PROD_W-1])
                phase_next = '0;
            else
                phase_next = phase_inc[PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            in_off_reg    <= '0;
            out_off_reg   <= '0;
            page_base_reg <= '0;
        end
        else if (advance)
        begin
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            in_off_reg    <= in_off_next;
            out_off_reg   <= out_off_next;
            page_base_reg <= page_base_next;
        end
    end

    // Result register
    logic [M_DATA_W-1:0] data_reg;
    logic                past_end_reg;
    logic                last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            past_end_reg <= done;
            if (done)
            begin
                // Past the last entry: zero every field but the flag.
                data_reg <= '0;
                last_reg <= 1'b0;
            end
            else
            begin
                data_reg <= {6'b0,
                             size == chunk_cap_reg,
                             cur_in_off,
                             cur_page,
                             size,
                             cur_phase == own_producer_reg,
                             cur_count};
                last_reg <= last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = past_end_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/dcdg_checker.sv =====
// Port-level checker for the chunk descriptor generator, bound to the top level.
// Depends on dcdg_pkg and dma_chunk_descriptor_generator_defines.svh.
`include "dma_chunk_descriptor_generator_defines.svh"

module dcdg_checker
    import dcdg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser,
    input logic                m_tlast
);

    // A stalled result holds still.
    `DCDG_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Past-end results carry no descriptor and never close the block.
    `DCDG_ASSERT_NOW(a_past_end_zero, m_tvalid && m_tuser[0], m_tdata == '0 && !m_tlast, "past-end result not clean")

    // With the output draining, the input side never pushes back.
    `DCDG_ASSERT_NOW(a_no_backpressure, m_tready, s_tready, "input stalled while output ready")

    // After an input transfer, a result stays on offer at the result register, stalled or not.
    `DCDG_ASSERT_NEXT(a_latency, s_tvalid && s_tready, ##1 m_tvalid, "result missing two cycles after input transfer")

endmodule

bind dma_chunk_descriptor_generator dcdg_checker u_dcdg_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for dma_chunk_descriptor_generator: predicts every descriptor
// from its own copy of the chunk walk and checks each result transfer. Depends on dcdg_pkg.
module tb;
    import dcdg_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS = 1900;   // stop the random walks after about this many
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off in the pressure test
    localparam int DRAIN_TAIL = 4;        // two-stage pipeline plus margin
    localparam int QUIET_LIMIT = 4000;    // cycles without any transfer or register write before giving up

    // One descriptor as the result channel carries it
    typedef struct packed {
        logic [ENTRY_W-1:0] entry_index;
        logic               owned;
        logic [WORD_W-1:0]  chunk_bytes;
        logic [WORD_W-1:0]  page_index;
        logic [WORD_W-1:0]  shard_offset;
        logic               whole_entry;
        logic               last_entry;
        logic               past_end;
    } descriptor_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [WORD_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 m_tlast;

    // Register copy of the bench
    logic [ENTRY_W-1:0] cfg_entry_total;
    logic [PROD_W-1:0]  cfg_producer_total;
    logic [PHASE_W-1:0] cfg_own_producer;
    logic [WORD_W-1:0]  cfg_chunk_cap;
    logic [WORD_W-1:0]  cfg_in_shard;
    logic [WORD_W-1:0]  cfg_tiles;
    logic [WORD_W-1:0]  cfg_out_shard;
    logic [WORD_W-1:0]  cfg_block_size;

    // Walk state of the bench
    logic [WORD_W-1:0]  walk_cursor;
    logic [ENTRY_W-1:0] walk_entry;
    logic [PHASE_W-1:0] walk_phase;
    logic [WORD_W-1:0]  walk_in_off;
    logic [WORD_W-1:0]  walk_out_off;
    logic [WORD_W-1:0]  walk_page;

    descriptor_t pending_descs[$];   // descriptors still owed by the block, oldest first

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  hold_off_cycles = 0;        // set by a test, consumed by the result sink
    bit  force_gapless = 0;          // keep the sender offering back to back
    bit  send_steady = 0;

    dma_chunk_descriptor_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [0] restart, [7:1] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [23:0] entry_index, [24] owned, [56:25] chunk_bytes,
                                   // [88:57] page_index, [120:89] shard_offset,
                                   // [121] whole_entry, [127:122] zero
        .m_tuser   (m_tuser),      // [0] past_end
        .m_tlast   (m_tlast)       // last_entry
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Advance the walk by one step and return the descriptor the block owes for it.
    function automatic descriptor_t walk_next_chunk(logic restart);
        descriptor_t d;
        logic [WORD_W-1:0] in_left;
        logic [WORD_W-1:0] blk_left;
        logic [WORD_W-1:0] out_space;
        logic [WORD_W-1:0] size;
        logic [PROD_W-1:0] next_phase;
        d = '0;
        if (restart)
        begin
            walk_cursor  = '0;
            walk_entry   = '0;
            walk_phase   = '0;
            walk_in_off  = '0;
            walk_out_off = '0;
            walk_page    = '0;
        end
        // Everything done: flag it, leave the walk untouched
        if (walk_entry >= cfg_entry_total)
        begin
            d.past_end = 1'b1;
            return d;
        end
        // Room left in each limit; an offset at or past its size leaves no room
        in_left   = (walk_in_off < cfg_in_shard) ? cfg_in_shard - walk_in_off : '0;
        blk_left  = (walk_cursor < cfg_block_size) ? cfg_block_size - walk_cursor : '0;
        out_space = (walk_out_off < cfg_out_shard) ? cfg_out_shard - walk_out_off : '0;
        if (blk_left < in_left)
            in_left = blk_left;
        size = cfg_chunk_cap;
        if (in_left < size)
            size = in_left;
        if (out_space < size)
            size = out_space;

        d.entry_index  = walk_entry;
        d.owned        = (walk_phase == cfg_own_producer);
        d.chunk_bytes  = size;
        d.page_index   = walk_page;
        d.shard_offset = walk_in_off;
        d.whole_entry  = (size == cfg_chunk_cap);
        d.last_entry   = ({1'b0, walk_entry} + 25'd1 == {1'b0, cfg_entry_total});

        walk_cursor = walk_cursor + size;
        // Close a shard when the chunk reaches its end; a stuck offset stays put
        if (walk_in_off < cfg_in_shard)
        begin
            if ({1'b0, walk_in_off} + {1'b0, size} >= {1'b0, cfg_in_shard})
            begin
                walk_in_off = '0;
                walk_page   = walk_page + cfg_tiles;
            end
            else
                walk_in_off = walk_in_off + size;
        end
        if (walk_out_off < cfg_out_shard)
        begin
            if ({1'b0, walk_out_off} + {1'b0, size} >= {1'b0, cfg_out_shard})
                walk_out_off = '0;
            else
                walk_out_off = walk_out_off + size;
        end
        // Round-robin owner phase, wrapping at the producer count or past 63
        next_phase = {1'b0, walk_phase} + 7'd1;
        if (next_phase >= cfg_producer_total || next_phase > 7'd63)
            next_phase = '0;
        walk_phase = next_phase[PHASE_W-1:0];
        walk_entry = walk_entry + ENTRY_W'(1);
        return d;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Draw a register value: mostly small sizes so walks cross many shard
    // boundaries, now and then the extremes and full-width values.
    function automatic logic [WORD_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
        int unsigned sel;
        sel = $urandom_range(0, 15);
        case (idx)
            REG_ENTRY_TOTAL:
                return (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFF_FFFF : $urandom_range(1, 60);
            REG_PRODUCER_TOTAL:
                return (sel == 0) ? 32'd0 : (sel == 1) ? $urandom_range(65, 127) :
                       (sel == 2) ? 32'd64 : $urandom_range(1, 8);
            REG_OWN_PRODUCER:
                return (sel == 0) ? 32'd63 : (sel == 1) ? $urandom_range(0, 63) :
                       $urandom_range(0, 7);
            REG_TILES_PER_IN:
                return (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
            REG_BLOCK_SIZE:
                return (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF :
                       (sel == 2) ? $urandom : $urandom_range(0, 300);
            REG_CHUNK_CAP:
                return (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF :
                       (sel == 2) ? $urandom : $urandom_range(1, 20);
            default:   // shard sizes
                return (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF :
                       (sel == 2) ? $urandom : $urandom_range(1, 24);
        endcase
    endfunction

    // Write one register and mirror it; then wait with the enable low so write enables never abut.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENTRY_TOTAL:    cfg_entry_total    = value[ENTRY_W-1:0];
            REG_PRODUCER_TOTAL: cfg_producer_total = value[PROD_W-1:0];
            REG_OWN_PRODUCER:   cfg_own_producer   = value[PHASE_W-1:0];
            REG_CHUNK_CAP:      cfg_chunk_cap      = value;
            REG_IN_SHARD_SIZE:  cfg_in_shard       = value;
            REG_TILES_PER_IN:   cfg_tiles          = value;
            REG_OUT_SHARD_SIZE: cfg_out_shard      = value;
            REG_BLOCK_SIZE:     cfg_block_size     = value;
        endcase
        @(posedge clk);
    endtask

    task automatic load_random_setup(bit all_regs);
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = CFG_IDX_W'(i);
            if (all_regs || $urandom_range(0, 3) != 0)
                write_reg(idx, pick_reg_value(idx));
        end
    endtask

    // Offer one step after a random gap, hold it until the transfer, then
    // record what the block owes for it. Valid stays high for the next call.
    task automatic send_item(logic restart);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = (force_gapless || send_steady) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
        pending_descs = {pending_descs, walk_next_chunk(restart)};
    endtask

    // Drop valid and hold until every owed descriptor has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_descs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Register defaults give an empty block: every step reports past end.
    task automatic test_reset_defaults();
        send_item(1'b0);
        send_item(1'b1);
        wait_drained();
    endtask

    // Short block that crosses both shard kinds, wraps the page index
    // and runs past its last entry.
    task automatic test_block_walk();
        write_reg(REG_ENTRY_TOTAL, 5);
        write_reg(REG_PRODUCER_TOTAL, 3);
        write_reg(REG_OWN_PRODUCER, 2);
        write_reg(REG_CHUNK_CAP, 4);
        write_reg(REG_IN_SHARD_SIZE, 6);
        write_reg(REG_TILES_PER_IN, 32'hFFFF_FFFF);
        write_reg(REG_OUT_SHARD_SIZE, 5);
        write_reg(REG_BLOCK_SIZE, 13);
        send_item(1'b1);
        repeat (6) send_item(1'b0);
        send_item(1'b1);   // restart after the block is done
        wait_drained();
    endtask

    // Every register but the tiles count at its top value, then zero cap, zero shards, no producers.
    task automatic test_register_extremes();
        write_reg(REG_ENTRY_TOTAL, 32'hFF_FFFF);
        write_reg(REG_PRODUCER_TOTAL, 127);
        write_reg(REG_OWN_PRODUCER, 63);
        write_reg(REG_CHUNK_CAP, 32'hFFFF_FFFF);
        write_reg(REG_IN_SHARD_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_OUT_SHARD_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_BLOCK_SIZE, 32'hFFFF_FFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        wait_drained();
        write_reg(REG_ENTRY_TOTAL, 3);
        write_reg(REG_PRODUCER_TOTAL, 0);
        write_reg(REG_OWN_PRODUCER, 0);
        write_reg(REG_CHUNK_CAP, 0);
        write_reg(REG_IN_SHARD_SIZE, 0);
        write_reg(REG_TILES_PER_IN, 0);
        write_reg(REG_OUT_SHARD_SIZE, 0);
        write_reg(REG_BLOCK_SIZE, 0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        wait_drained();
    endtask

    // Shrink the input shard under the cursor without a restart: the offset
    // ends up past the shard and the walk stalls on zero-byte chunks.
    task automatic test_midblock_change();
        write_reg(REG_ENTRY_TOTAL, 20);
        write_reg(REG_PRODUCER_TOTAL, 4);
        write_reg(REG_OWN_PRODUCER, 1);
        write_reg(REG_CHUNK_CAP, 8);
        write_reg(REG_IN_SHARD_SIZE, 24);
        write_reg(REG_TILES_PER_IN, 3);
        write_reg(REG_OUT_SHARD_SIZE, 32);
        write_reg(REG_BLOCK_SIZE, 100);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();
        write_reg(REG_IN_SHARD_SIZE, 10);
        send_item(1'b0);
        send_item(1'b0);
        wait_drained();
    endtask

    // Hold the result side for a long stretch while steps keep coming, so the
    // pipeline fills and the block stalls its input.
    task automatic test_backpressure();
        load_random_setup(1'b1);
        force_gapless   = 1'b1;
        hold_off_cycles = HOLD_CYCLES;
        send_item(1'b1);
        repeat (PRESSURE_ITEMS - 1) send_item($urandom_range(0, 31) == 0);
        force_gapless = 1'b0;
        wait_drained();
    endtask

    // Random setups, each walked from a restart in most phases; the rest
    // carry the old walk into the new registers.
    task automatic test_random_walks();
        int sent;
        int phase_len;
        bit restart_first;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            load_random_setup($urandom_range(0, 3) == 0);
            restart_first = ($urandom_range(0, 7) != 0);
            phase_len = $urandom_range(10, 80);
            for (int i = 0; i < phase_len; i++)
            begin
                send_item((i == 0 && restart_first) || $urandom_range(0, 31) == 0);
                sent++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        // Mirror the register defaults and the cleared walk
        cfg_entry_total    = '0;
        cfg_producer_total = 7'd1;
        cfg_own_producer   = '0;
        cfg_chunk_cap      = 32'd1;
        cfg_in_shard       = 32'd1;
        cfg_tiles          = 32'd1;
        cfg_out_shard      = 32'd1;
        cfg_block_size     = '0;
        walk_cursor  = '0;
        walk_entry   = '0;
        walk_phase   = '0;
        walk_in_off  = '0;
        walk_out_off = '0;
        walk_page    = '0;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_block_walk();
        test_register_extremes();
        test_midblock_change();
        test_backpressure();
        test_random_walks();

        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result sink: random stall before each transfer, long hold-off on request,
    // with stretches of no stalls at all.
    initial
    begin : result_sink
        int gap;
        bit steady;
        steady = 0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 13);
            if (hold_off_cycles > 0)
            begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest owed descriptor.
    always @(posedge clk)
    begin : result_check
        descriptor_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_descs.size() == 0)
            begin
                $error("result transfer with no descriptor owed");
                mismatches++;
            end
            else
            begin
                want = pending_descs.pop_front();
                check_field("entry_index", WORD_W'(want.entry_index),
                            WORD_W'(m_tdata[23:0]));
                check_field("owned", WORD_W'(want.owned), WORD_W'(m_tdata[24]));
                check_field("chunk_bytes", want.chunk_bytes, m_tdata[56:25]);
                check_field("page_index", want.page_index, m_tdata[88:57]);
                check_field("shard_offset", want.shard_offset, m_tdata[120:89]);
                check_field("whole_entry", WORD_W'(want.whole_entry),
                            WORD_W'(m_tdata[121]));
                check_field("last_entry", WORD_W'(want.last_entry), WORD_W'(m_tlast));
                check_field("past_end", WORD_W'(want.past_end), WORD_W'(m_tuser[0]));
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer or register write.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
